/* rtl/mts_pkg.sv */
// Shared constants and types for the max-tracking stack.
package mts_pkg;

    localparam int DEPTH  = 128;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CNT_W-1:0]         count_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [1:0]               status_t;

    localparam logic    CMD_PUSH = 1'b0;
    localparam logic    CMD_POP  = 1'b1;

    localparam status_t ST_DONE       = 2'd0;
    localparam status_t ST_PUSH_FULL  = 2'd1;
    localparam status_t ST_POP_EMPTY  = 2'd2;

endpackage

/* rtl/max_tracking_stack.sv */
// Max-tracking stack: value store, monotonic max store and control.
//
// A LIFO of signed 32-bit values that reports its running maximum after every
// push or pop. Values live in a main memory; a second memory keeps a
// non-decreasing run of maxima, written on a push whose value is at least the
// current max top and dropped on a pop that removes that same value. For each
// input transfer the stores' tops (main top, max top and the entry below the
// max top) are read when it is accepted in the idle state, then the result is
// formed and written back in the execute state. A full push or empty pop is
// rejected with a status and leaves the stack untouched. The result sits in
// an output register; while it is stalled no new input is taken. There is no
// clearing pass after reset: only entries below the current counts are used.
module max_tracking_stack
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             cmd,
    input  mts_pkg::data_t   value,
    output logic             out_valid,
    input  logic             out_stall,
    output mts_pkg::status_t status,
    output mts_pkg::data_t   popped_value,
    output mts_pkg::data_t   max_value,
    output logic             max_valid,
    output mts_pkg::count_t  fill_count
);
    import mts_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Storage
    data_t main_mem [DEPTH];
    data_t max_mem  [DEPTH];

    logic    state_reg, state_next;
    count_t  main_count_reg, main_count_next;
    count_t  max_count_reg, max_count_next;
    logic    cmd_reg;
    data_t   value_reg;

    // Registered read data: main top, max top, entry below max top
    data_t   main_top_reg;
    data_t   max_top_reg;
    data_t   max_below_reg;

    logic    out_valid_reg;
    status_t status_reg, status_next;
    data_t   popped_reg, popped_next;
    data_t   max_value_reg, max_value_next;
    logic    max_valid_reg;
    count_t  fill_reg;

    logic    in_fire;
    logic    main_we, max_we;
    addr_t   main_waddr, max_waddr;
    data_t   new_max_top;

    assign in_stall = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_fire  = in_valid && !in_stall;

    // Read addresses follow the counts; wrap of an empty count is never used
    always_ff @(posedge clk)
    begin
        main_top_reg  <= main_mem[ADDR_W'(main_count_reg - 1'b1)];
        max_top_reg   <= max_mem[ADDR_W'(max_count_reg - 1'b1)];
        max_below_reg <= max_mem[ADDR_W'(max_count_reg - 2'd2)];
    end

    always_ff @(posedge clk)
    begin
        if (main_we)
        begin
            main_mem[main_waddr] <= value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (max_we)
        begin
            max_mem[max_waddr] <= value_reg;
        end
    end

    assign main_waddr = ADDR_W'(main_count_reg);
    assign max_waddr  = ADDR_W'(max_count_reg);

    // Execute step
    always_comb
    begin
        state_next      = state_reg;
        main_count_next = main_count_reg;
        max_count_next  = max_count_reg;
        main_we         = 1'b0;
        max_we          = 1'b0;
        status_next     = ST_DONE;
        popped_next     = '0;
        new_max_top     = max_top_reg;

        if (state_reg == ST_IDLE)
        begin
            if (in_fire)
            begin
                state_next = ST_EXEC;
            end
        end
        else
        begin
            state_next = ST_IDLE;
            if (cmd_reg == CMD_PUSH)
            begin
                if (main_count_reg == CNT_W'(DEPTH))
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    main_we         = 1'b1;
                    main_count_next = main_count_reg + 1'b1;
                    if ((max_count_reg == '0) || (max_top_reg <= value_reg))
                    begin
                        if (max_count_reg != CNT_W'(DEPTH))
                        begin
                            max_we         = 1'b1;
                            max_count_next = max_count_reg + 1'b1;
                            new_max_top    = value_reg;
                        end
                    end
                end
            end
            else
            begin
                if (main_count_reg == '0)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    popped_next     = main_top_reg;
                    main_count_next = main_count_reg - 1'b1;
                    if ((max_count_reg != '0) && (max_top_reg == main_top_reg))
                    begin
                        max_count_next = max_count_reg - 1'b1;
                        new_max_top    = max_below_reg;
                    end
                end
            end
        end

        if ((main_count_next != '0) && (max_count_next != '0))
        begin
            max_value_next = new_max_top;
        end
        else
        begin
            max_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            main_count_reg <= '0;
            max_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            main_count_reg <= main_count_next;
            max_count_reg  <= max_count_next;
            if (state_reg == ST_EXEC)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
        end
        if (state_reg == ST_EXEC)
        begin
            status_reg    <= status_next;
            popped_reg    <= popped_next;
            max_value_reg <= max_value_next;
            max_valid_reg <= (main_count_next != '0);
            fill_reg      <= main_count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign max_value    = max_value_reg;
    assign max_valid    = max_valid_reg;
    assign fill_count   = fill_reg;

endmodule
